[design/ec_scalar_multiply_prime_field_assert.svh]
// assertion macros shared by the checker
`ifndef EC_SCALAR_MULTIPLY_PRIME_FIELD_ASSERT_SVH
`define EC_SCALAR_MULTIPLY_PRIME_FIELD_ASSERT_SVH

// same-cycle implication
`define ECSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ECSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ecsm_pkg.sv]
package ecsm_pkg;

	localparam int FIELD_BITS_DEF  = 16;
	localparam int SCALAR_BITS_DEF = 16;
	localparam int IO_W            = 16;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd1;

	localparam logic [IO_W-1:0] CURVE_A_RST = 16'd2;
	localparam logic [IO_W-1:0] MODULUS_RST = 16'd5;

	// smallest modulus with a usable field
	localparam int MIN_MODULUS = 3;

	typedef enum logic [2:0] {
		OP_NONE, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV
	} op_t;

	typedef enum logic [3:0] {
		R_X, R_Y, R_BX, R_BY, R_CA, R_S, R_T, R_U,
		R_R0, R_R1, R_T0, R_T1, R_Q, R_ZERO, R_ONE, R_P
	} reg_sel_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_SCALAR = 2'd1,
		ST_NO_INVERSE  = 2'd2
	} status_t;

	typedef struct packed {
		logic     go;
		op_t      op;
		reg_sel_t src_a;
		reg_sel_t src_b;
		reg_sel_t dst;
		logic     load_in;
		logic     out_load;
		logic     out_inf;
		status_t  out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic k_zero;
		logic p_small;
		logic base_inf;
		logic pt_equal;
		logic t_zero;
		logic r1_zero;
		logic r0_one;
		logic kbit;
		logic out_busy;
	} dp_stat_t;

	typedef enum logic [5:0] {
		S_IDLE, S_CHECK, S_RED_X, S_RED_Y, S_RED_A, S_INIT_X, S_INIT_Y, S_FIND, S_LOOP,
		S_DBL_START, S_DBL_TEST, S_ADD_START, S_ADD_COPY_X, S_ADD_COPY_Y, S_ADD_TEST,
		S_INV_P, S_INV_R1, S_INV_T0, S_INV_T1, S_INV_LOOP, S_INV_DIV, S_INV_SH0,
		S_INV_SH1, S_INV_MUL, S_INV_SUB, S_INV_T0N, S_INV_T1N, S_INV_DONE,
		S_DBLN_SQ, S_DBLN_2, S_DBLN_3, S_DBLN_A, S_ADDN_SUB, S_SLOPE,
		S_FIN_SQ, S_FIN_X1, S_FIN_X2, S_FIN_D, S_FIN_M, S_FIN_Y, S_FIN_X,
		S_STEP_END, S_DONE
	} state_t;

endpackage

[design/ecsm_datapath.sv]
module ecsm_datapath #(
	parameter int FIELD_BITS  = 16,
	parameter int SCALAR_BITS = 16,
	localparam int IDX_W = $clog2(SCALAR_BITS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ecsm_pkg::dp_cmd_t                 cmd,
	input  logic [IDX_W-1:0]                  bit_idx,
	output ecsm_pkg::dp_stat_t                stat,
	input  logic                              cfg_valid,
	input  logic [ecsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ecsm_pkg::IO_W-1:0]         cfg_data,
	input  logic [ecsm_pkg::IO_W-1:0]         in_x,
	input  logic [ecsm_pkg::IO_W-1:0]         in_y,
	input  logic [ecsm_pkg::IO_W-1:0]         in_k,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ecsm_pkg::IO_W-1:0]         out_x,
	output logic [ecsm_pkg::IO_W-1:0]         out_y,
	output logic                              out_inf,
	output logic [1:0]                        out_status
);
	import ecsm_pkg::*;

	localparam int CNT_W = $clog2(FIELD_BITS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FIELD_BITS - 1);

	logic [FIELD_BITS-1:0] x_q, y_q, bx_q, by_q, ca_q, s_q, t_q, u_q;
	logic [FIELD_BITS-1:0] r0_q, r1_q, t0_q, t1_q, qt_q;
	logic [FIELD_BITS-1:0] a_cfg_q, p_q;
	logic [SCALAR_BITS-1:0] k_q;

	// iterative unit shared by multiply and divide
	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FIELD_BITS-1:0] ma_q, mb_q, macc_q, drem_q;

	logic [FIELD_BITS-1:0] opa, opb, wdata;
	logic [FIELD_BITS:0]   p_ext, sum, dif, m_dbl, m_red, m_add, div_r;
	logic [FIELD_BITS-1:0] mul_next, rem_next, quo_next;
	logic                  single, wr, div_bit;

	function automatic logic [FIELD_BITS-1:0] rd(reg_sel_t s,
		logic [FIELD_BITS-1:0] x, logic [FIELD_BITS-1:0] y, logic [FIELD_BITS-1:0] bx,
		logic [FIELD_BITS-1:0] by, logic [FIELD_BITS-1:0] ca, logic [FIELD_BITS-1:0] sl,
		logic [FIELD_BITS-1:0] t, logic [FIELD_BITS-1:0] u, logic [FIELD_BITS-1:0] r0,
		logic [FIELD_BITS-1:0] r1, logic [FIELD_BITS-1:0] t0, logic [FIELD_BITS-1:0] t1,
		logic [FIELD_BITS-1:0] q, logic [FIELD_BITS-1:0] p);
		logic [FIELD_BITS-1:0] v;
		unique case (s)
			R_X:    v = x;
			R_Y:    v = y;
			R_BX:   v = bx;
			R_BY:   v = by;
			R_CA:   v = ca;
			R_S:    v = sl;
			R_T:    v = t;
			R_U:    v = u;
			R_R0:   v = r0;
			R_R1:   v = r1;
			R_T0:   v = t0;
			R_T1:   v = t1;
			R_Q:    v = q;
			R_ZERO: v = '0;
			R_ONE:  v = FIELD_BITS'(1);
			R_P:    v = p;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign opa   = rd(cmd.src_a, x_q, y_q, bx_q, by_q, ca_q, s_q, t_q, u_q,
		r0_q, r1_q, t0_q, t1_q, qt_q, p_q);
	assign opb   = rd(cmd.src_b, x_q, y_q, bx_q, by_q, ca_q, s_q, t_q, u_q,
		r0_q, r1_q, t0_q, t1_q, qt_q, p_q);
	assign p_ext = {1'b0, p_q};

	// modular add and subtract on reduced operands
	always_comb begin
		sum = {1'b0, opa} + {1'b0, opb};
		if (sum >= p_ext)
			sum = sum - p_ext;
		if (opa >= opb)
			dif = {1'b0, opa} - {1'b0, opb};
		else
			dif = {1'b0, opa} + p_ext - {1'b0, opb};
	end

	// one multiply step, msb of the left operand first
	always_comb begin
		m_dbl = {macc_q, 1'b0};
		m_red = (m_dbl >= p_ext) ? m_dbl - p_ext : m_dbl;
		m_add = m_red + (ma_q[FIELD_BITS-1] ? {1'b0, mb_q} : '0);
		if (m_add >= p_ext)
			m_add = m_add - p_ext;
		mul_next = m_add[FIELD_BITS-1:0];
	end

	// one restoring divide step
	always_comb begin
		div_r   = {drem_q, ma_q[FIELD_BITS-1]};
		div_bit = div_r >= {1'b0, mb_q};
		if (div_bit)
			div_r = div_r - {1'b0, mb_q};
		rem_next = div_r[FIELD_BITS-1:0];
		quo_next = {ma_q[FIELD_BITS-2:0], div_bit};
	end

	assign single    = (cmd.op == OP_MOV) || (cmd.op == OP_ADD) || (cmd.op == OP_SUB);
	assign stat.done = cmd.go && (single || (busy_q && cnt_q == LAST));
	assign wr        = stat.done;

	always_comb begin
		case (cmd.op)
			OP_MOV:  wdata = opa;
			OP_ADD:  wdata = sum[FIELD_BITS-1:0];
			OP_SUB:  wdata = dif[FIELD_BITS-1:0];
			OP_MUL:  wdata = mul_next;
			OP_DIV:  wdata = rem_next;
			default: wdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.go && !busy_q && !single) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == LAST)
				busy_q <= 1'b0;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go && !busy_q && !single) begin
			ma_q   <= opa;
			mb_q   <= opb;
			macc_q <= '0;
			drem_q <= '0;
		end else if (busy_q) begin
			macc_q <= mul_next;
			drem_q <= rem_next;
			ma_q   <= (cmd.op == OP_DIV) ? quo_next : {ma_q[FIELD_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			bx_q <= FIELD_BITS'(in_x);
			by_q <= FIELD_BITS'(in_y);
			ca_q <= a_cfg_q;
			k_q  <= SCALAR_BITS'(in_k);
		end
		if (wr && cmd.op == OP_DIV)
			qt_q <= quo_next;
		if (wr) begin
			unique case (cmd.dst)
				R_X:  x_q  <= wdata;
				R_Y:  y_q  <= wdata;
				R_BX: bx_q <= wdata;
				R_BY: by_q <= wdata;
				R_CA: ca_q <= wdata;
				R_S:  s_q  <= wdata;
				R_T:  t_q  <= wdata;
				R_U:  u_q  <= wdata;
				R_R0: r0_q <= wdata;
				R_R1: r1_q <= wdata;
				R_T0: t0_q <= wdata;
				R_T1: t1_q <= wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_cfg_q <= FIELD_BITS'(CURVE_A_RST);
			p_q     <= FIELD_BITS'(MODULUS_RST);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CURVE_A: a_cfg_q <= FIELD_BITS'(cfg_data);
				CFG_MODULUS: p_q     <= FIELD_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	assign stat.k_zero   = (k_q == '0);
	assign stat.p_small  = (p_q < FIELD_BITS'(MIN_MODULUS));
	assign stat.base_inf = (bx_q == '0) && (by_q == '0);
	assign stat.pt_equal = (x_q == bx_q) && (y_q == by_q);
	assign stat.t_zero   = (t_q == '0);
	assign stat.r1_zero  = (r1_q == '0);
	assign stat.r0_one   = (r0_q == FIELD_BITS'(1));
	assign stat.kbit     = k_q[bit_idx];
	assign stat.out_busy = out_valid && !out_ready;

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.out_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= cmd.out_status;
			out_inf    <= cmd.out_inf && (cmd.out_status == ST_OK);
			if (cmd.out_inf || cmd.out_status != ST_OK) begin
				out_x <= '0;
				out_y <= '0;
			end else begin
				out_x <= IO_W'(x_q);
				out_y <= IO_W'(y_q);
			end
		end
	end

endmodule

[design/ecsm_ctrl.sv]
module ecsm_ctrl #(
	parameter int SCALAR_BITS = 16,
	localparam int IDX_W = $clog2(SCALAR_BITS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ecsm_pkg::dp_stat_t stat,
	output ecsm_pkg::dp_cmd_t  cmd,
	output logic [IDX_W-1:0]   bit_idx
);
	import ecsm_pkg::*;

	state_t     state_q, state_n;
	logic [IDX_W-1:0] idx_q;
	logic       acc_inf_q, use_bx_q, phase_q;
	status_t    status_q;

	assign bit_idx  = idx_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:       if (in_valid) state_n = S_CHECK;
			S_CHECK:      state_n = (stat.k_zero || stat.p_small) ? S_DONE : S_RED_X;
			S_RED_X:      if (stat.done) state_n = S_RED_Y;
			S_RED_Y:      if (stat.done) state_n = S_RED_A;
			S_RED_A:      if (stat.done) state_n = S_INIT_X;
			S_INIT_X:     if (stat.done) state_n = S_INIT_Y;
			S_INIT_Y:     if (stat.done) state_n = S_FIND;
			S_FIND:       if (stat.kbit) state_n = S_LOOP;
			S_LOOP:       state_n = (idx_q == '0) ? S_DONE : S_DBL_START;
			S_DBL_START: begin
				if (acc_inf_q)
					state_n = S_STEP_END;
				else if (stat.done)
					state_n = S_DBL_TEST;
			end
			S_DBL_TEST:   state_n = stat.t_zero ? S_STEP_END : S_INV_P;
			S_ADD_START: begin
				if (acc_inf_q)
					state_n = S_ADD_COPY_X;
				else if (stat.base_inf)
					state_n = S_STEP_END;
				else if (stat.pt_equal)
					state_n = S_DBL_START;
				else if (stat.done)
					state_n = S_ADD_TEST;
			end
			S_ADD_COPY_X: if (stat.done) state_n = S_ADD_COPY_Y;
			S_ADD_COPY_Y: if (stat.done) state_n = S_STEP_END;
			S_ADD_TEST:   state_n = stat.t_zero ? S_STEP_END : S_INV_P;
			S_INV_P:      if (stat.done) state_n = S_INV_R1;
			S_INV_R1:     if (stat.done) state_n = S_INV_T0;
			S_INV_T0:     if (stat.done) state_n = S_INV_T1;
			S_INV_T1:     if (stat.done) state_n = S_INV_LOOP;
			S_INV_LOOP: begin
				if (!stat.r1_zero)
					state_n = S_INV_DIV;
				else
					state_n = stat.r0_one ? S_INV_DONE : S_DONE;
			end
			S_INV_DIV:    if (stat.done) state_n = S_INV_SH0;
			S_INV_SH0:    if (stat.done) state_n = S_INV_SH1;
			S_INV_SH1:    if (stat.done) state_n = S_INV_MUL;
			S_INV_MUL:    if (stat.done) state_n = S_INV_SUB;
			S_INV_SUB:    if (stat.done) state_n = S_INV_T0N;
			S_INV_T0N:    if (stat.done) state_n = S_INV_T1N;
			S_INV_T1N:    if (stat.done) state_n = S_INV_LOOP;
			S_INV_DONE:   if (stat.done) state_n = use_bx_q ? S_ADDN_SUB : S_DBLN_SQ;
			S_DBLN_SQ:    if (stat.done) state_n = S_DBLN_2;
			S_DBLN_2:     if (stat.done) state_n = S_DBLN_3;
			S_DBLN_3:     if (stat.done) state_n = S_DBLN_A;
			S_DBLN_A:     if (stat.done) state_n = S_SLOPE;
			S_ADDN_SUB:   if (stat.done) state_n = S_SLOPE;
			S_SLOPE:      if (stat.done) state_n = S_FIN_SQ;
			S_FIN_SQ:     if (stat.done) state_n = S_FIN_X1;
			S_FIN_X1:     if (stat.done) state_n = S_FIN_X2;
			S_FIN_X2:     if (stat.done) state_n = S_FIN_D;
			S_FIN_D:      if (stat.done) state_n = S_FIN_M;
			S_FIN_M:      if (stat.done) state_n = S_FIN_Y;
			S_FIN_Y:      if (stat.done) state_n = S_FIN_X;
			S_FIN_X:      if (stat.done) state_n = S_STEP_END;
			S_STEP_END:   state_n = (!phase_q && stat.kbit) ? S_ADD_START : S_LOOP;
			S_DONE:       if (!stat.out_busy) state_n = S_IDLE;
			default:      state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.op         = OP_NONE;
		cmd.src_a      = R_ZERO;
		cmd.src_b      = R_ZERO;
		cmd.dst        = R_ZERO;
		cmd.out_status = status_q;
		cmd.out_inf    = acc_inf_q;
		cmd.load_in    = (state_q == S_IDLE) && in_valid;
		cmd.out_load   = (state_q == S_DONE) && !stat.out_busy;
		unique case (state_q)
			S_RED_X:      begin cmd.op = OP_DIV; cmd.src_a = R_BX; cmd.src_b = R_P; cmd.dst = R_BX; end
			S_RED_Y:      begin cmd.op = OP_DIV; cmd.src_a = R_BY; cmd.src_b = R_P; cmd.dst = R_BY; end
			S_RED_A:      begin cmd.op = OP_DIV; cmd.src_a = R_CA; cmd.src_b = R_P; cmd.dst = R_CA; end
			S_INIT_X:     begin cmd.op = OP_MOV; cmd.src_a = R_BX; cmd.dst = R_X; end
			S_INIT_Y:     begin cmd.op = OP_MOV; cmd.src_a = R_BY; cmd.dst = R_Y; end
			S_DBL_START:  begin cmd.op = OP_ADD; cmd.src_a = R_Y; cmd.src_b = R_Y; cmd.dst = R_T; end
			S_ADD_START:  begin cmd.op = OP_SUB; cmd.src_a = R_BX; cmd.src_b = R_X; cmd.dst = R_T; end
			S_ADD_COPY_X: begin cmd.op = OP_MOV; cmd.src_a = R_BX; cmd.dst = R_X; end
			S_ADD_COPY_Y: begin cmd.op = OP_MOV; cmd.src_a = R_BY; cmd.dst = R_Y; end
			S_INV_P:      begin cmd.op = OP_MOV; cmd.src_a = R_P; cmd.dst = R_R0; end
			S_INV_R1:     begin cmd.op = OP_MOV; cmd.src_a = R_T; cmd.dst = R_R1; end
			S_INV_T0:     begin cmd.op = OP_MOV; cmd.src_a = R_ZERO; cmd.dst = R_T0; end
			S_INV_T1:     begin cmd.op = OP_MOV; cmd.src_a = R_ONE; cmd.dst = R_T1; end
			S_INV_DIV:    begin cmd.op = OP_DIV; cmd.src_a = R_R0; cmd.src_b = R_R1; cmd.dst = R_U; end
			S_INV_SH0:    begin cmd.op = OP_MOV; cmd.src_a = R_R1; cmd.dst = R_R0; end
			S_INV_SH1:    begin cmd.op = OP_MOV; cmd.src_a = R_U; cmd.dst = R_R1; end
			S_INV_MUL:    begin cmd.op = OP_MUL; cmd.src_a = R_Q; cmd.src_b = R_T1; cmd.dst = R_U; end
			S_INV_SUB:    begin cmd.op = OP_SUB; cmd.src_a = R_T0; cmd.src_b = R_U; cmd.dst = R_U; end
			S_INV_T0N:    begin cmd.op = OP_MOV; cmd.src_a = R_T1; cmd.dst = R_T0; end
			S_INV_T1N:    begin cmd.op = OP_MOV; cmd.src_a = R_U; cmd.dst = R_T1; end
			S_INV_DONE:   begin cmd.op = OP_MOV; cmd.src_a = R_T0; cmd.dst = R_S; end
			S_DBLN_SQ:    begin cmd.op = OP_MUL; cmd.src_a = R_X; cmd.src_b = R_X; cmd.dst = R_T; end
			S_DBLN_2:     begin cmd.op = OP_ADD; cmd.src_a = R_T; cmd.src_b = R_T; cmd.dst = R_U; end
			S_DBLN_3:     begin cmd.op = OP_ADD; cmd.src_a = R_U; cmd.src_b = R_T; cmd.dst = R_U; end
			S_DBLN_A:     begin cmd.op = OP_ADD; cmd.src_a = R_U; cmd.src_b = R_CA; cmd.dst = R_U; end
			S_ADDN_SUB:   begin cmd.op = OP_SUB; cmd.src_a = R_BY; cmd.src_b = R_Y; cmd.dst = R_U; end
			S_SLOPE:      begin cmd.op = OP_MUL; cmd.src_a = R_U; cmd.src_b = R_S; cmd.dst = R_S; end
			S_FIN_SQ:     begin cmd.op = OP_MUL; cmd.src_a = R_S; cmd.src_b = R_S; cmd.dst = R_T; end
			S_FIN_X1:     begin cmd.op = OP_SUB; cmd.src_a = R_T; cmd.src_b = R_X; cmd.dst = R_T; end
			S_FIN_X2: begin
				cmd.op = OP_SUB; cmd.src_a = R_T; cmd.dst = R_T;
				cmd.src_b = use_bx_q ? R_BX : R_X;
			end
			S_FIN_D:      begin cmd.op = OP_SUB; cmd.src_a = R_X; cmd.src_b = R_T; cmd.dst = R_U; end
			S_FIN_M:      begin cmd.op = OP_MUL; cmd.src_a = R_S; cmd.src_b = R_U; cmd.dst = R_U; end
			S_FIN_Y:      begin cmd.op = OP_SUB; cmd.src_a = R_U; cmd.src_b = R_Y; cmd.dst = R_Y; end
			S_FIN_X:      begin cmd.op = OP_MOV; cmd.src_a = R_T; cmd.dst = R_X; end
			default: ;
		endcase
		// special cases of doubling and addition skip the unit
		if (state_q == S_DBL_START)
			cmd.go = !acc_inf_q;
		else if (state_q == S_ADD_START)
			cmd.go = !acc_inf_q && !stat.base_inf && !stat.pt_equal;
		else
			cmd.go = (cmd.op != OP_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			acc_inf_q <= 1'b0;
			use_bx_q  <= 1'b0;
			phase_q   <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE:       if (in_valid) idx_q <= IDX_W'(SCALAR_BITS - 1);
				S_CHECK: begin
					acc_inf_q <= 1'b0;
					if (stat.k_zero)
						status_q <= ST_ZERO_SCALAR;
					else if (stat.p_small)
						status_q <= ST_NO_INVERSE;
					else
						status_q <= ST_OK;
				end
				S_INIT_Y:     if (stat.done) acc_inf_q <= stat.base_inf;
				S_FIND:       if (!stat.kbit) idx_q <= idx_q - IDX_W'(1);
				S_LOOP: begin
					if (idx_q != '0) begin
						idx_q    <= idx_q - IDX_W'(1);
						phase_q  <= 1'b0;
						use_bx_q <= 1'b0;
					end
				end
				S_DBL_TEST:   if (stat.t_zero) acc_inf_q <= 1'b1;
				S_ADD_TEST: begin
					if (stat.t_zero)
						acc_inf_q <= 1'b1;
					else
						use_bx_q <= 1'b1;
				end
				S_ADD_COPY_Y: if (stat.done) acc_inf_q <= stat.base_inf;
				S_INV_LOOP:   if (stat.r1_zero && !stat.r0_one) status_q <= ST_NO_INVERSE;
				S_FIN_X:      if (stat.done) acc_inf_q <= 1'b0;
				S_STEP_END:   if (!phase_q && stat.kbit) phase_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[design/ec_scalar_multiply_prime_field.sv]
// channel  | dir | words                              | handshake
// s_       | in  | tdata: point_x, point_y, scalar    | s_tvalid / s_tready
// m_       | out | tdata: result_x, result_y          | m_tvalid / m_tready
//          |     | tuser: at_infinity, status         |
// cfg_     | in  | cfg_index, cfg_data                | cfg_valid / cfg_ready
//
// one word at a time; a modular multiply or divide runs on the
// one shared iterative unit, while add, subtract and move bypass it
// each inversion runs up to about 1.44*FIELD_BITS euclid rounds,
// each of one divide and one multiply
// a zero scalar or a too small modulus goes from the check state straight to done
// arst_n clears the control and sets the registers to curve_a 2, modulus 5
// a finished result waits in the output register; the next word is taken meanwhile
// and only its own result waits for m_tready
module ec_scalar_multiply_prime_field #(
	parameter int FIELD_BITS  = ecsm_pkg::FIELD_BITS_DEF,
	parameter int SCALAR_BITS = ecsm_pkg::SCALAR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // point_x [15:0], point_y [31:16], scalar [47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_x [15:0], result_y [31:16]
	output logic [2:0]  m_tuser,   // at_infinity [0], status [2:1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ecsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import ecsm_pkg::*;

	localparam int IDX_W = $clog2(SCALAR_BITS);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDX_W-1:0] bit_idx;
	logic [IO_W-1:0]  res_x, res_y;
	logic             res_inf;
	logic [1:0]       res_status;

	// registers are always writable
	assign cfg_ready = 1'b1;

	ecsm_ctrl #(
		.SCALAR_BITS(SCALAR_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd),
		.bit_idx  (bit_idx)
	);

	ecsm_datapath #(
		.FIELD_BITS  (FIELD_BITS),
		.SCALAR_BITS (SCALAR_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.bit_idx    (bit_idx),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_x       (s_tdata[15:0]),
		.in_y       (s_tdata[31:16]),
		.in_k       (s_tdata[47:32]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_x      (res_x),
		.out_y      (res_y),
		.out_inf    (res_inf),
		.out_status (res_status)
	);

	assign m_tdata = {res_y, res_x};
	assign m_tuser = {res_status, res_inf};

endmodule

[design/ecsm_checker.sv]
`include "ec_scalar_multiply_prime_field_assert.svh"

module ecsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import ecsm_pkg::*;

	// a word is worked on alone, so input is closed right after a take
	`ECSM_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken twice in a row")

	// infinity carries zero coordinates
	`ECSM_ASSERT_SAME(a_inf_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0, "infinity with coordinates")

	// an error word is all zeros apart from its code
	`ECSM_ASSERT_SAME(a_err_zero, clk, arst_n, m_tvalid && m_tuser[2:1] != ST_OK, m_tdata == '0 && !m_tuser[0], "error word not cleared")

	// stalled result word holds
	`ECSM_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled word changed")

endmodule

bind ec_scalar_multiply_prime_field ecsm_checker u_ecsm_checker (.*);
